// ----- hdl/bleadp_pkg.sv -----
`timescale 1ns / 1ps

package bleadp_pkg;

   // depth of the queue between the byte classifier and the parser
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 64;

   // advertising data types
   localparam logic [7:0] AD_LIST16_PART = 8'h02;
   localparam logic [7:0] AD_LIST16_FULL = 8'h03;
   localparam logic [7:0] AD_LIST32_PART = 8'h04;
   localparam logic [7:0] AD_LIST32_FULL = 8'h05;
   localparam logic [7:0] AD_LIST128_PART = 8'h06;
   localparam logic [7:0] AD_LIST128_FULL = 8'h07;
   localparam logic [7:0] AD_NAME_SHORT = 8'h08;
   localparam logic [7:0] AD_NAME_FULL = 8'h09;
   localparam logic [7:0] AD_SDATA16 = 8'h16;
   localparam logic [7:0] AD_SDATA32 = 8'h20;
   localparam logic [7:0] AD_SDATA128 = 8'h21;
   localparam logic [7:0] AD_VENDOR = 8'hFF;

   // target uuid size codes
   localparam logic [1:0] UUID_NONE = 2'd0;
   localparam logic [1:0] UUID_16 = 2'd1;
   localparam logic [1:0] UUID_32 = 2'd2;
   localparam logic [1:0] UUID_128 = 2'd3;

   typedef enum logic [1:0] {
      CSR_UUID_MODE = 2'd0,
      CSR_UUID_LOW = 2'd1,
      CSR_UUID_HIGH = 2'd2,
      CSR_VENDOR = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_TYPE,
      PH_DATA
   } phase_type;

   typedef enum logic [3:0] {
      KIND_OTHER,
      KIND_NAME,
      KIND_LIST16,
      KIND_LIST32,
      KIND_LIST128,
      KIND_SDATA16,
      KIND_SDATA32,
      KIND_SDATA128,
      KIND_VENDOR
   } kind_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
      logic       len_zero;
      kind_type   kind;
   } item_type;

   typedef struct packed {
      logic         valid;
      item_type     item;
   } queue_head_type;

   typedef struct packed {
      logic [1:0]   uuid_size_mode;
      logic [127:0] target_uuid;
      logic [15:0]  target_vendor;
   } cfg_type;

   function automatic kind_type classify(input logic [7:0] b);
      kind_type k;
      begin
         unique case (b)
            AD_LIST16_PART, AD_LIST16_FULL: k = KIND_LIST16;
            AD_LIST32_PART, AD_LIST32_FULL: k = KIND_LIST32;
            AD_LIST128_PART, AD_LIST128_FULL: k = KIND_LIST128;
            AD_NAME_SHORT, AD_NAME_FULL: k = KIND_NAME;
            AD_SDATA16: k = KIND_SDATA16;
            AD_SDATA32: k = KIND_SDATA32;
            AD_SDATA128: k = KIND_SDATA128;
            AD_VENDOR: k = KIND_VENDOR;
            default: k = KIND_OTHER;
         endcase
         return k;
      end
   endfunction

endpackage

// ----- hdl/bleadp_if.sv -----
`timescale 1ns / 1ps

interface bleadp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface bleadp_rsp_if;
   logic       valid;
   logic       ready;
   logic       malformed;
   logic       service_listed;
   logic       service_data_found;
   logic       vendor_found;
   logic       name_present;
   logic [6:0] entry_count;

   modport source (output valid, output malformed, output service_listed,
                   output service_data_found, output vendor_found, output name_present,
                   output entry_count, input ready);
   modport sink (input valid, input malformed, input service_listed,
                 input service_data_found, input vendor_found, input name_present,
                 input entry_count, output ready);
endinterface

// ----- hdl/ble_adv_data_parse_filter_top.sv -----
`timescale 1ns / 1ps

// BLE advertising data parser and filter. Payload bytes enter on req_chan one item per
// cycle while the queue has room; each byte is classified and queued in a two-entry
// queue, then a parser walks the length-type-value structures and matches the target
// UUID in service UUID lists and service data, the target vendor in vendor-specific
// data, and notes name structures. The byte marked last produces one verdict item on
// rsp_chan; all other bytes produce none. The parser takes one byte per cycle from the
// queue head while no verdict byte waits; the verdict is captured in the output register
// and offered on rsp_chan from there. A verdict byte waits in the queue only while the
// output register still holds a verdict not yet taken.
// Registers on the csr port: 0 uuid size mode, 1 uuid bytes 0..7, 2 uuid bytes 8..15,
// 3 vendor id; write them only between packets.

module ble_adv_data_parse_filter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   bleadp_req_if.sink                            req_chan,
   bleadp_rsp_if.source                          rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [bleadp_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [bleadp_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import bleadp_pkg::*;

   logic [1:0]     mode_ff, mode_in;
   logic [63:0]    uuid_low_ff, uuid_low_in;
   logic [63:0]    uuid_high_ff, uuid_high_in;
   logic [15:0]    vendor_ff, vendor_in;
   cfg_type        cfg;
   queue_head_type head;
   logic           pop;

   always_comb begin
      mode_in = mode_ff;
      uuid_low_in = uuid_low_ff;
      uuid_high_in = uuid_high_ff;
      vendor_in = vendor_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_UUID_MODE: mode_in = csr_wdata[1:0];
            CSR_UUID_LOW: uuid_low_in = csr_wdata;
            CSR_UUID_HIGH: uuid_high_in = csr_wdata;
            CSR_VENDOR: vendor_in = csr_wdata[15:0];
            default: mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
         uuid_low_ff <= 64'd0;
         uuid_high_ff <= 64'd0;
         vendor_ff <= 16'd0;
      end else begin
         mode_ff <= mode_in;
         uuid_low_ff <= uuid_low_in;
         uuid_high_ff <= uuid_high_in;
         vendor_ff <= vendor_in;
      end
   end

   assign cfg.uuid_size_mode = mode_ff;
   assign cfg.target_uuid = {uuid_high_ff, uuid_low_ff};
   assign cfg.target_vendor = vendor_ff;

   bleadp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   bleadp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- hdl/bleadp_front.sv -----
`timescale 1ns / 1ps

module bleadp_front (
   input  logic                       clock,
   input  logic                       reset,
   bleadp_req_if.sink                 req_chan,
   output bleadp_pkg::queue_head_type head,
   input  logic                       pop
);
   import bleadp_pkg::*;

   item_type                   queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]   count_ff, count_in;
   logic                       push;
   item_type                   new_item;

   assign req_chan.ready = (count_ff != QueueCntWidth'(QueueDepth));
   assign push = req_chan.valid && req_chan.ready;

   // classify the byte as a possible type byte while it enters
   always_comb begin
      new_item.byte_value = req_chan.byte_value;
      new_item.last_byte = req_chan.last_byte;
      new_item.len_zero = (req_chan.byte_value == 8'd0);
      new_item.kind = classify(req_chan.byte_value);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item = queue_ff[rd_ptr_ff];

endmodule

// ----- hdl/bleadp_back.sv -----
`timescale 1ns / 1ps

module bleadp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bleadp_pkg::cfg_type        cfg,
   input  bleadp_pkg::queue_head_type head,
   output logic                       pop,
   bleadp_rsp_if.source               rsp_chan
);
   import bleadp_pkg::*;

   phase_type  phase_ff, phase_in, phase_step;
   logic [7:0] bytes_left_ff, bytes_left_in, bytes_left_step;
   kind_type   kind_ff, kind_in, kind_step;
   logic [7:0] pos_ff, pos_in, pos_step;
   logic       ceq_ff, ceq_in, ceq_step;
   logic [7:0] vlow_ff, vlow_in, vlow_step;
   logic [3:0] flags_ff, flags_in, flags_step;
   logic       bad_ff, bad_in, bad_step;
   logic [6:0] count_ff, count_in, count_step;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_malformed_ff, rsp_malformed_in;
   logic [3:0] rsp_flags_ff, rsp_flags_in;
   logic [6:0] rsp_count_ff, rsp_count_in;

   logic       rsp_free;
   logic       work;
   logic       verdict;
   logic       len_bad;
   logic [7:0] left_dec;
   logic [3:0] mask;
   logic [3:0] off;
   logic       list_on;
   logic       sdata_on;
   logic [7:0] tgt_list;
   logic [7:0] tgt_sdata;
   logic       eq_list;
   logic       eq_sdata;
   logic [7:0] b;

   assign b = head.item.byte_value;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   // only the verdict byte waits on the output register
   assign pop = head.valid && (!head.item.last_byte || rsp_free);
   assign work = pop && !bad_ff;
   assign verdict = pop && head.item.last_byte;
   assign len_bad = head.item.len_zero || head.item.last_byte;
   assign left_dec = bytes_left_ff - 8'd1;

   always_comb begin
      unique case (cfg.uuid_size_mode)
         UUID_16: mask = 4'd1;
         UUID_32: mask = 4'd3;
         default: mask = 4'd15;
      endcase
   end

   assign list_on = (cfg.uuid_size_mode == UUID_16 && kind_ff == KIND_LIST16) ||
                    (cfg.uuid_size_mode == UUID_32 && kind_ff == KIND_LIST32) ||
                    (cfg.uuid_size_mode == UUID_128 && kind_ff == KIND_LIST128);
   assign sdata_on = (cfg.uuid_size_mode == UUID_16 && kind_ff == KIND_SDATA16) ||
                     (cfg.uuid_size_mode == UUID_32 && kind_ff == KIND_SDATA32) ||
                     (cfg.uuid_size_mode == UUID_128 && kind_ff == KIND_SDATA128);

   assign off = pos_ff[3:0] & mask;
   assign tgt_list = cfg.target_uuid[{off, 3'b000} +: 8];
   assign tgt_sdata = cfg.target_uuid[{pos_ff[3:0], 3'b000} +: 8];
   assign eq_list = (off == 4'd0 || ceq_ff) && (b == tgt_list);
   assign eq_sdata = (pos_ff == 8'd0 || ceq_ff) && (b == tgt_sdata);

   // next parse phase
   always_comb begin
      phase_step = phase_ff;
      if (work) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (!len_bad) begin
                  phase_step = PH_TYPE;
               end
            end
            PH_TYPE, PH_DATA: begin
               phase_step = (left_dec == 8'd0) ? PH_LEN : PH_DATA;
            end
            default: phase_step = PH_LEN;
         endcase
      end
      phase_in = verdict ? PH_LEN : phase_step;
   end

   // per-byte datapath
   always_comb begin
      bytes_left_step = bytes_left_ff;
      kind_step = kind_ff;
      pos_step = pos_ff;
      ceq_step = ceq_ff;
      vlow_step = vlow_ff;
      flags_step = flags_ff;
      bad_step = bad_ff;
      count_step = count_ff;
      if (work) begin
         unique case (phase_ff)
            PH_LEN: begin
               if (len_bad) begin
                  bad_step = 1'b1;
               end else begin
                  bytes_left_step = b;
               end
            end
            PH_TYPE: begin
               kind_step = head.item.kind;
               pos_step = 8'd0;
               ceq_step = 1'b1;
               if (head.item.kind == KIND_NAME) begin
                  flags_step[3] = 1'b1;
               end
               bytes_left_step = left_dec;
            end
            PH_DATA: begin
               if (list_on) begin
                  ceq_step = eq_list;
                  if (off == mask && eq_list) begin
                     flags_step[0] = 1'b1;
                  end
               end
               if (sdata_on && pos_ff <= {4'd0, mask}) begin
                  ceq_step = eq_sdata;
                  if (pos_ff[3:0] == mask && eq_sdata) begin
                     flags_step[1] = 1'b1;
                  end
               end
               if (kind_ff == KIND_VENDOR) begin
                  if (pos_ff == 8'd0) begin
                     vlow_step = b;
                  end else if (pos_ff == 8'd1 && {b, vlow_ff} == cfg.target_vendor) begin
                     flags_step[2] = 1'b1;
                  end
               end
               if (pos_ff != 8'hFF) begin
                  pos_step = pos_ff + 8'd1;
               end
               bytes_left_step = left_dec;
            end
            default: bad_step = 1'b1;
         endcase
         if (phase_ff != PH_LEN && left_dec == 8'd0 && count_ff != 7'h7F) begin
            count_step = count_ff + 7'd1;
         end
         // structure still open on the final byte
         if (head.item.last_byte && phase_step != PH_LEN) begin
            bad_step = 1'b1;
         end
      end
   end

   // verdict capture and per-packet clear
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_malformed_in = rsp_malformed_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (verdict) begin
         rsp_valid_in = 1'b1;
         rsp_malformed_in = bad_step;
         rsp_flags_in = bad_step ? 4'd0 : flags_step;
         rsp_count_in = count_step;
      end
      bytes_left_in = verdict ? 8'd0 : bytes_left_step;
      kind_in = verdict ? KIND_OTHER : kind_step;
      pos_in = verdict ? 8'd0 : pos_step;
      ceq_in = verdict ? 1'b1 : ceq_step;
      vlow_in = verdict ? 8'd0 : vlow_step;
      flags_in = verdict ? 4'd0 : flags_step;
      bad_in = verdict ? 1'b0 : bad_step;
      count_in = verdict ? 7'd0 : count_step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEN;
         bytes_left_ff <= 8'd0;
         kind_ff <= KIND_OTHER;
         pos_ff <= 8'd0;
         ceq_ff <= 1'b1;
         vlow_ff <= 8'd0;
         flags_ff <= 4'd0;
         bad_ff <= 1'b0;
         count_ff <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bytes_left_ff <= bytes_left_in;
         kind_ff <= kind_in;
         pos_ff <= pos_in;
         ceq_ff <= ceq_in;
         vlow_ff <= vlow_in;
         flags_ff <= flags_in;
         bad_ff <= bad_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_malformed_ff <= rsp_malformed_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.malformed = rsp_malformed_ff;
   assign rsp_chan.service_listed = rsp_flags_ff[0];
   assign rsp_chan.service_data_found = rsp_flags_ff[1];
   assign rsp_chan.vendor_found = rsp_flags_ff[2];
   assign rsp_chan.name_present = rsp_flags_ff[3];
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

// ----- tb/tb_ble_adv_data_parse_filter_top.sv -----
`timescale 1ns / 1ps

module tb_ble_adv_data_parse_filter_top;
   import bleadp_pkg::*;

   localparam int RandomItems = 1900;
   localparam int PhaseCount = 8;
   localparam int HoldCycles = 300;
   localparam int WatchdogLimit = 3000;
   localparam int SettleCycles = 8;

   typedef struct packed {
      logic       malformed;
      logic       service_listed;
      logic       service_data_found;
      logic       vendor_found;
      logic       name_present;
      logic [6:0] entry_count;
   } verdict_type;

   typedef struct {
      logic [7:0]  b;
      logic        fin;
      bit          pinned;
      verdict_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   bleadp_req_if req_if ();
   bleadp_rsp_if rsp_if ();

   ble_adv_data_parse_filter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // short packets with verdicts that follow directly from the layout rules
   stim_row_type dir_rows [22] = '{
      // zero length as the only byte
      '{8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
      // length byte as the final byte
      '{8'h05, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
      // full name structure
      '{8'h02, 1'b0, 1'b0, '0},
      '{AD_NAME_FULL, 1'b0, 1'b0, '0},
      '{8'h41, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd1}},
      // vendor id zero matches the vendor register after reset
      '{8'h03, 1'b0, 1'b0, '0},
      '{AD_VENDOR, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd1}},
      // name structure, then a length byte as the final byte, flags dropped
      '{8'h02, 1'b0, 1'b0, '0},
      '{AD_NAME_SHORT, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd1}},
      // structure runs past the end of the packet
      '{8'h04, 1'b0, 1'b0, '0},
      '{AD_NAME_FULL, 1'b0, 1'b0, '0},
      '{8'h01, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
      // vendor type without data
      '{8'h01, 1'b0, 1'b0, '0},
      '{AD_VENDOR, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd1}},
      // uuid mode none never matches a list
      '{8'h03, 1'b0, 1'b0, '0},
      '{AD_LIST16_FULL, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd1}}
   };

   // parser copy: configuration
   logic [1:0]  cfg_mode;
   logic [63:0] cfg_lo;
   logic [63:0] cfg_hi;
   logic [15:0] cfg_vendor;

   // parser copy: packet state
   phase_type   pr_phase;
   logic [7:0]  pr_left;
   logic [7:0]  pr_kind;
   logic [7:0]  pr_pos;
   logic        pr_chunk_eq;
   logic [7:0]  pr_vlow;
   logic [3:0]  pr_flags;
   logic        pr_bad;
   logic [6:0]  pr_count;

   verdict_type verdict_q [$];

   // settings the packet generator aims at
   logic [1:0]  cur_mode;
   logic [63:0] cur_lo;
   logic [63:0] cur_hi;
   logic [15:0] cur_vendor;

   logic [7:0] pkt [$];

   bit          pin_on;
   verdict_type pin_verdict;
   bit          quiet;
   bit          hold_request;
   int          hold_left;
   int          stall_left;

   int errors;
   int bytes_sent;
   int packets_sent;
   int idle_cycles;
   int verdicts_seen;
   int malformed_seen;
   int match_seen;
   int name_seen;

   function automatic int uuid_size_bytes(input logic [1:0] m);
      case (m)
         UUID_16: return 2;
         UUID_32: return 4;
         UUID_128: return 16;
         default: return 0;
      endcase
   endfunction

   function automatic logic [7:0] uuid_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input int i);
      int j;
      j = i & 15;
      if (j < 8)
         return lo[8*j +: 8];
      return hi[8*(j-8) +: 8];
   endfunction

   function automatic bit is_list_type(input logic [7:0] k, input int sz);
      case (sz)
         2: return k == AD_LIST16_PART || k == AD_LIST16_FULL;
         4: return k == AD_LIST32_PART || k == AD_LIST32_FULL;
         16: return k == AD_LIST128_PART || k == AD_LIST128_FULL;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit is_service_data_type(input logic [7:0] k, input int sz);
      case (sz)
         2: return k == AD_SDATA16;
         4: return k == AD_SDATA32;
         16: return k == AD_SDATA128;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [7:0] list_code(input int sz, input bit full);
      case (sz)
         2: return full ? AD_LIST16_FULL : AD_LIST16_PART;
         4: return full ? AD_LIST32_FULL : AD_LIST32_PART;
         default: return full ? AD_LIST128_FULL : AD_LIST128_PART;
      endcase
   endfunction

   function automatic void clear_parse_state();
      pr_phase = PH_LEN;
      pr_left = '0;
      pr_kind = '0;
      pr_pos = '0;
      pr_chunk_eq = 1'b1;
      pr_vlow = '0;
      pr_flags = '0;
      pr_bad = 1'b0;
      pr_count = '0;
   endfunction

   function automatic void close_structure();
      if (pr_count != 7'd127)
         pr_count++;
      pr_phase = PH_LEN;
   endfunction

   // one payload byte through the parser; returns 1 when a verdict is due
   function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                     output verdict_type v);
      int sz;
      int off;
      bit eq;
      logic [3:0] f;
      sz = uuid_size_bytes(cfg_mode);
      v = '0;
      if (!pr_bad) begin
         case (pr_phase)
            PH_LEN: begin
               if (b == 8'h00 || fin) begin
                  pr_bad = 1'b1;
               end else begin
                  pr_left = b;
                  pr_phase = PH_TYPE;
               end
            end
            PH_TYPE: begin
               pr_kind = b;
               pr_pos = '0;
               pr_chunk_eq = 1'b1;
               if (b == AD_NAME_SHORT || b == AD_NAME_FULL)
                  pr_flags[3] = 1'b1;
               pr_left--;
               if (pr_left == 8'h00)
                  close_structure();
               else
                  pr_phase = PH_DATA;
            end
            default: begin
               if (sz != 0 && is_list_type(pr_kind, sz)) begin
                  off = pr_pos & (sz - 1);
                  eq = (off == 0 || pr_chunk_eq) && b == uuid_byte(cfg_lo, cfg_hi, off);
                  pr_chunk_eq = eq;
                  if (off == sz - 1 && eq)
                     pr_flags[0] = 1'b1;
               end
               if (sz != 0 && is_service_data_type(pr_kind, sz) && pr_pos < sz) begin
                  eq = (pr_pos == 0 || pr_chunk_eq) && b == uuid_byte(cfg_lo, cfg_hi, pr_pos);
                  pr_chunk_eq = eq;
                  if (pr_pos == sz - 1 && eq)
                     pr_flags[1] = 1'b1;
               end
               if (pr_kind == AD_VENDOR) begin
                  if (pr_pos == 8'd0)
                     pr_vlow = b;
                  else if (pr_pos == 8'd1 && {b, pr_vlow} == cfg_vendor)
                     pr_flags[2] = 1'b1;
               end
               if (pr_pos != 8'd255)
                  pr_pos++;
               pr_left--;
               if (pr_left == 8'h00)
                  close_structure();
            end
         endcase
         if (fin && pr_phase != PH_LEN)
            pr_bad = 1'b1;
      end
      if (!fin)
         return 1'b0;
      f = pr_bad ? 4'h0 : pr_flags;
      v.malformed = pr_bad;
      v.service_listed = f[0];
      v.service_data_found = f[1];
      v.vendor_found = f[2];
      v.name_present = f[3];
      v.entry_count = pr_count;
      clear_parse_state();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic int draw_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // sampling, prediction, checking and watchdog
   always @(posedge clock) begin
      verdict_type pv;
      verdict_type want;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_UUID_MODE: cfg_mode = csr_wdata[1:0];
               CSR_UUID_LOW: cfg_lo = csr_wdata;
               CSR_UUID_HIGH: cfg_hi = csr_wdata;
               CSR_VENDOR: cfg_vendor = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            if (parse_byte(req_if.byte_value, req_if.last_byte, pv))
               verdict_q.push_back(pin_on ? pin_verdict : pv);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            verdicts_seen++;
            malformed_seen += int'(rsp_if.malformed);
            match_seen += int'(rsp_if.service_listed | rsp_if.service_data_found
                               | rsp_if.vendor_found);
            name_seen += int'(rsp_if.name_present);
            if (verdict_q.size() == 0) begin
               report_mismatch("verdict with none pending, entry_count",
                               int'(rsp_if.entry_count), 0);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_if.malformed !== want.malformed)
                  report_mismatch("malformed", int'(rsp_if.malformed),
                                  int'(want.malformed));
               if (rsp_if.service_listed !== want.service_listed)
                  report_mismatch("service_listed", int'(rsp_if.service_listed),
                                  int'(want.service_listed));
               if (rsp_if.service_data_found !== want.service_data_found)
                  report_mismatch("service_data_found", int'(rsp_if.service_data_found),
                                  int'(want.service_data_found));
               if (rsp_if.vendor_found !== want.vendor_found)
                  report_mismatch("vendor_found", int'(rsp_if.vendor_found),
                                  int'(want.vendor_found));
               if (rsp_if.name_present !== want.name_present)
                  report_mismatch("name_present", int'(rsp_if.name_present),
                                  int'(want.name_present));
               if (rsp_if.entry_count !== want.entry_count)
                  report_mismatch("entry_count", int'(rsp_if.entry_count),
                                  int'(want.entry_count));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no item moved for %0d cycles, %0d verdicts pending",
                     idle_cycles, verdict_q.size());
            $display("FAIL ble_adv_data_parse_filter_top");
            $finish;
         end
      end
   end

   // verdict receiver with random stalls and one long hold on request
   initial begin
      rsp_if.ready = 1'b0;
      hold_left = 0;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = draw_gap();
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin, input bit pinned,
                            input verdict_type want);
      int g;
      g = draw_gap();
      repeat (g) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.byte_value <= b;
      req_if.last_byte <= fin;
      pin_on = pinned;
      pin_verdict = want;
      do
         @(posedge clock);
      while (!req_if.ready);
      bytes_sent++;
      if (fin)
         packets_sent++;
   endtask

   task automatic send_packet();
      foreach (pkt[i])
         send_byte(pkt[i], i == pkt.size() - 1, 1'b0, '0);
   endtask

   // waits for an idle block, then writes all four registers
   task automatic apply_settings(input logic [1:0] m, input logic [63:0] lo,
                                 input logic [63:0] hi, input logic [15:0] vid);
      logic [63:0] junk;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      cur_mode = m;
      cur_lo = lo;
      cur_hi = hi;
      cur_vendor = vid;
      junk = {$urandom, $urandom};
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_UUID_MODE;
      csr_wdata <= {junk[63:2], m};
      @(negedge clock);
      csr_index <= CSR_UUID_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_UUID_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_index <= CSR_VENDOR;
      csr_wdata <= {junk[47:0], vid};
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // appends one well-formed structure aimed at the current target
   task automatic add_structure();
      logic [7:0] body [$];
      logic [7:0] t;
      logic [7:0] x;
      logic [15:0] vid;
      int r, gsz, n, f, cut;
      gsz = uuid_size_bytes(cur_mode);
      if (gsz == 0)
         case ($urandom_range(0, 2))
            0: gsz = 2;
            1: gsz = 4;
            default: gsz = 16;
         endcase
      r = $urandom_range(0, 99);
      if (r < 30) begin
         t = list_code(gsz, bit'($urandom_range(0, 1)));
         n = $urandom_range(1, 3);
         repeat (n) begin
            r = $urandom_range(0, 3);
            f = $urandom_range(0, gsz - 1);
            for (int i = 0; i < gsz; i++) begin
               x = uuid_byte(cur_lo, cur_hi, i);
               if (r == 3)
                  x = 8'($urandom_range(0, 255));
               else if (r == 2 && i == f)
                  x = x ^ (8'h01 << $urandom_range(0, 7));
               body.push_back(x);
            end
         end
         // partial trailing chunk
         if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, gsz - 1);
            for (int i = 0; i < cut; i++)
               body.push_back(uuid_byte(cur_lo, cur_hi, i));
         end
      end else if (r < 50) begin
         case (gsz)
            2: t = AD_SDATA16;
            4: t = AD_SDATA32;
            default: t = AD_SDATA128;
         endcase
         cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gsz - 1) : gsz;
         f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gsz - 1) : -1;
         for (int i = 0; i < cut; i++) begin
            x = uuid_byte(cur_lo, cur_hi, i);
            if (i == f)
               x = x ^ (8'h01 << $urandom_range(0, 7));
            body.push_back(x);
         end
         repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(0, 255)));
      end else if (r < 65) begin
         t = AD_VENDOR;
         vid = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) : cur_vendor;
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 2;
         if (n > 0)
            body.push_back(vid[7:0]);
         if (n > 1)
            body.push_back(vid[15:8]);
         if (n == 2)
            repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
      end else if (r < 75) begin
         t = $urandom_range(0, 1) ? AD_NAME_FULL : AD_NAME_SHORT;
         repeat ($urandom_range(0, 5)) body.push_back(8'($urandom_range(0, 255)));
      end else if (r < 98) begin
         t = 8'($urandom_range(0, 255));
         repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(0, 255)));
      end else begin
         // long structure, up to the largest length byte
         t = $urandom_range(0, 1) ? list_code(gsz, 1'b1) : 8'($urandom_range(0, 255));
         n = $urandom_range(100, 254);
         for (int i = 0; i < n; i++)
            body.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : uuid_byte(cur_lo, cur_hi, i % gsz));
      end
      pkt.push_back(8'(body.size() + 1));
      pkt.push_back(t);
      foreach (body[i])
         pkt.push_back(body[i]);
   endtask

   task automatic build_packet();
      int r, cut;
      pkt.delete();
      r = $urandom_range(0, 99);
      if (r < 6) begin
         repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 4)) add_structure();
         if (r < 14) begin
            // truncated packet
            cut = $urandom_range(1, pkt.size() - 1);
            pkt = pkt[0:cut-1];
         end else if (r < 19) begin
            pkt.push_back(8'h00);
            repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      logic [1:0] m;
      logic [63:0] lo, hi;
      logic [15:0] vid;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.byte_value = '0;
      req_if.last_byte = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pin_on = 1'b0;
      pin_verdict = '0;
      quiet = 1'b0;
      hold_request = 1'b0;
      errors = 0;
      bytes_sent = 0;
      packets_sent = 0;
      idle_cycles = 0;
      verdicts_seen = 0;
      malformed_seen = 0;
      match_seen = 0;
      name_seen = 0;
      cfg_mode = '0;
      cfg_lo = '0;
      cfg_hi = '0;
      cfg_vendor = '0;
      cur_mode = '0;
      cur_lo = '0;
      cur_hi = '0;
      cur_vendor = '0;
      clear_parse_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].pinned, dir_rows[i].want);
      bytes_sent = 0;

      for (int p = 0; p < PhaseCount; p++) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         vid = 16'($urandom_range(0, 65535));
         m = 2'($urandom_range(0, 3));
         case (p)
            0: begin
               m = UUID_16;
               lo = '1;
               hi = '1;
               vid = 16'hFFFF;
            end
            1: begin
               m = UUID_128;
               lo = '0;
               hi = '0;
               vid = 16'h0000;
            end
            2: m = UUID_32;
            3: m = UUID_NONE;
            4: m = UUID_128;
            default: ;
         endcase
         apply_settings(m, lo, hi, vid);
         // one phase runs without any idling
         quiet = (p == 2);
         if (p == 3) begin
            // receiver holds off while packets keep coming
            hold_request = 1'b1;
            repeat (6) begin
               build_packet();
               send_packet();
            end
         end
         if (p == PhaseCount - 1) begin
            // more structures than the count can hold
            pkt.delete();
            repeat (130) begin
               pkt.push_back(8'h01);
               pkt.push_back(8'($urandom_range(0, 255)));
            end
            send_packet();
         end
         while (bytes_sent < (p + 1) * RandomItems / PhaseCount) begin
            build_packet();
            send_packet();
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d packets, %0d random payload bytes, %0d register settings",
               packets_sent, bytes_sent, PhaseCount + 1);
      $display("verdicts: %0d total, %0d malformed, %0d with a target match, %0d with a name",
               verdicts_seen, malformed_seen, match_seen, name_seen);
      if (errors == 0) begin
         $display("PASS ble_adv_data_parse_filter_top");
      end else begin
         $display("FAIL ble_adv_data_parse_filter_top");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/bleadp_pkg.sv
hdl/bleadp_if.sv
hdl/bleadp_front.sv
hdl/bleadp_back.sv
hdl/ble_adv_data_parse_filter_top.sv
tb/tb_ble_adv_data_parse_filter_top.sv
